FILE: hw/rtl/nsfc_pkg.sv
// Package for the NMEA sentence framer/checker.
// Holds the queue item and result types, character codes and digit decode.
// No dependencies.
package nsfc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_UP_A   = 8'h41;

    localparam int unsigned TYPE_WINDOW = 6;
    localparam int unsigned NUM_TYPES   = 4;

    localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
        24'h524D43,   // RMC
        24'h475341,   // GSA
        24'h474741,   // GGA
        24'h475356    // GSV
    };

    localparam logic [2:0] TYPE_OTHER = 3'd0;
    localparam logic [2:0] TYPE_RMC   = 3'd1;
    localparam logic [2:0] TYPE_GSA   = 3'd2;
    localparam logic [2:0] TYPE_GGA   = 3'd3;
    localparam logic [2:0] TYPE_GSV   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_LIMIT    = 2'd2;

    localparam logic [8:0]  HEX_CLAMP = 9'd511;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
        logic       is_dollar;
        logic       is_cr;
        logic       is_sep;
        logic       is_star;
        logic [5:0] digit;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] sentence_type;
        logic [5:0] field_count;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic       forward;
    } t_result;

    function automatic logic [5:0] f_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - CH_LOW_A + 8'd10;
        end else if (c inside {[8'h41:8'h5A]}) begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[5:0];
    endfunction

endpackage

FILE: hw/rtl/nsfc_front.sv
// Front end of the NMEA framer: accepts bytes and classifies them.
// Depends on nsfc_pkg; feeds nsfc_queue.
module nsfc_front (
    input  logic           i_in_valid,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_chunk_end,
    input  logic           i_q_full,
    output logic           o_in_stall,
    output logic           o_push,
    output nsfc_pkg::t_item o_item
);
    import nsfc_pkg::*;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    always_comb begin
        o_item.rx_byte   = i_rx_byte;
        o_item.chunk_end = i_chunk_end;
        o_item.is_dollar = (i_rx_byte == CH_DOLLAR);
        o_item.is_cr     = (i_rx_byte == CH_CR);
        o_item.is_star   = (i_rx_byte == CH_STAR);
        o_item.is_sep    = (i_rx_byte == CH_COMMA) || (i_rx_byte == CH_STAR);
        o_item.digit     = f_digit(i_rx_byte);
    end

endmodule

FILE: hw/rtl/nsfc_queue.sv
// Two-entry queue of classified bytes between front and back.
// Depends on nsfc_pkg.
module nsfc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nsfc_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output nsfc_pkg::t_item o_item
);
    import nsfc_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/nsfc_back.sv
// Back end of the NMEA framer: sentence state, checksum, type match, result register.
// Depends on nsfc_pkg; pops items from nsfc_queue.
module nsfc_back #(
    parameter int unsigned MAX_LINE_BYTES  = 99,
    parameter int unsigned MAX_FIELDS      = 32,
    parameter int unsigned MAX_FIELD_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  nsfc_pkg::t_item   i_item,
    output logic              o_pop,
    input  logic              i_cfg_we,
    input  logic              i_cfg_forward_all_types,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output nsfc_pkg::t_result o_result
);
    import nsfc_pkg::*;

    localparam int unsigned LW = $clog2(MAX_LINE_BYTES + 1);
    localparam int unsigned FW = $clog2(MAX_FIELD_BYTES + 1);
    localparam logic [LW-1:0] LINE_LIM  = LW'(MAX_LINE_BYTES);
    localparam logic [FW-1:0] FIELD_LIM = FW'(MAX_FIELD_BYTES);
    localparam logic [5:0]    SEP_LIM   = 6'(MAX_FIELDS);
    localparam logic [LW-1:0] WIN_LIM   = LW'(TYPE_WINDOW);

    logic          r_fwd_all;
    logic          r_in_sentence;
    logic [LW-1:0] r_line_length;
    logic [5:0]    r_sep_count;
    logic [FW-1:0] r_field_length;
    logic [7:0]    r_xor;
    logic          r_star_seen;
    logic [8:0]    r_hex_acc;
    logic [23:0]   r_last3;
    logic [3:0]    r_type_flags;
    logic          r_limit;
    logic          r_out_valid;
    t_result       r_result;

    logic          n_in_sentence;
    logic [LW-1:0] n_line_length;
    logic [5:0]    n_sep_count;
    logic [FW-1:0] n_field_length;
    logic [7:0]    n_xor;
    logic          n_star_seen;
    logic [8:0]    n_hex_acc;
    logic [23:0]   n_last3;
    logic [3:0]    n_type_flags;
    logic          n_limit;
    t_result       n_result;

    logic          cur_in;
    logic [LW-1:0] cur_line;
    logic [5:0]    cur_sep;
    logic [FW-1:0] cur_field;
    logic [7:0]    cur_xor;
    logic          cur_star;
    logic [8:0]    cur_acc;
    logic [23:0]   cur_last3;
    logic [3:0]    cur_flags;
    logic          cur_limit;
    logic          take;
    logic          emit;
    logic [13:0]   acc_wide;
    logic [5:0]    sep_inc;
    logic [FW-1:0] field_inc;
    logic [LW-1:0] line_inc;
    logic [2:0]    stype;
    logic [1:0]    status;

    assign o_pop = i_q_valid & (~r_out_valid | ~i_out_stall);

    always_comb begin
        if (i_item.is_dollar) begin
            cur_in    = 1'b1;
            cur_line  = '0;
            cur_sep   = '0;
            cur_field = '0;
            cur_xor   = '0;
            cur_star  = 1'b0;
            cur_acc   = '0;
            cur_last3 = '0;
            cur_flags = '0;
            cur_limit = 1'b0;
        end else begin
            cur_in    = r_in_sentence;
            cur_line  = r_line_length;
            cur_sep   = r_sep_count;
            cur_field = r_field_length;
            cur_xor   = r_xor;
            cur_star  = r_star_seen;
            cur_acc   = r_hex_acc;
            cur_last3 = r_last3;
            cur_flags = r_type_flags;
            cur_limit = r_limit;
        end
        take = o_pop & cur_in & ~i_item.is_cr;
        emit = o_pop & cur_in & i_item.is_cr;
    end

    // per-byte sentence update
    always_comb begin
        n_last3      = cur_last3;
        n_type_flags = cur_flags;
        n_hex_acc    = cur_acc;
        n_star_seen  = cur_star;
        n_xor        = cur_xor;
        n_sep_count  = cur_sep;
        n_field_length = cur_field;
        n_limit      = cur_limit;
        n_line_length  = cur_line;
        acc_wide     = {1'b0, cur_acc, 4'b0} + {8'd0, i_item.digit};
        sep_inc      = (cur_sep < SEP_LIM) ? cur_sep + 6'd1 : cur_sep;
        field_inc    = (cur_field < FIELD_LIM) ? cur_field + FW'(1) : cur_field;
        line_inc     = cur_line + LW'(1);

        if (take) begin
            if (cur_sep == 6'd0 && !i_item.is_sep && cur_line < WIN_LIM) begin
                n_last3 = {cur_last3[15:0], i_item.rx_byte};
                if (cur_line >= LW'(2)) begin
                    for (int k = 0; k < NUM_TYPES; k++) begin
                        if (n_last3 == TYPE_NAMES[k]) begin
                            n_type_flags[k] = 1'b1;
                        end
                    end
                end
            end
            if (cur_star) begin
                n_hex_acc = (acc_wide > {5'd0, HEX_CLAMP}) ? HEX_CLAMP : acc_wide[8:0];
            end else if (i_item.is_star) begin
                n_star_seen = 1'b1;
            end else if (cur_line != '0) begin
                n_xor = cur_xor ^ i_item.rx_byte;
            end
            if (i_item.is_sep) begin
                n_field_length = '0;
                n_sep_count    = sep_inc;
                if (sep_inc >= SEP_LIM) begin
                    n_limit = 1'b1;
                end
            end else begin
                n_field_length = field_inc;
                if (field_inc >= FIELD_LIM) begin
                    n_limit = 1'b1;
                end
            end
            n_line_length = line_inc;
        end

        if (!o_pop) begin
            n_in_sentence = r_in_sentence;
        end else if (i_item.chunk_end || !cur_in || i_item.is_cr) begin
            n_in_sentence = 1'b0;
        end else begin
            n_in_sentence = (line_inc < LINE_LIM);
        end
    end

    // result at carriage return
    always_comb begin
        if (cur_flags[0]) begin
            stype = TYPE_RMC;
        end else if (cur_flags[1]) begin
            stype = TYPE_GSA;
        end else if (cur_flags[2]) begin
            stype = TYPE_GGA;
        end else if (cur_flags[3]) begin
            stype = TYPE_GSV;
        end else begin
            stype = TYPE_OTHER;
        end
        if (cur_limit) begin
            status = STATUS_LIMIT;
        end else if (!cur_star || cur_acc != {1'b0, cur_xor}) begin
            status = STATUS_BAD_SUM;
        end else begin
            status = STATUS_OK;
        end
        n_result.status            = status;
        n_result.sentence_type     = stype;
        n_result.field_count       = cur_sep;
        n_result.computed_checksum = cur_xor;
        n_result.received_checksum = cur_acc[8] ? 8'hFF : cur_acc[7:0];
        n_result.forward           = (status == STATUS_OK) &&
            (stype == TYPE_RMC || stype == TYPE_GSA || stype == TYPE_GGA || r_fwd_all);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_all      <= 1'b0;
            r_in_sentence  <= 1'b0;
            r_out_valid    <= 1'b0;
            r_line_length  <= '0;
            r_sep_count    <= '0;
            r_field_length <= '0;
            r_xor          <= '0;
            r_star_seen    <= 1'b0;
            r_hex_acc      <= '0;
            r_last3        <= '0;
            r_type_flags   <= '0;
            r_limit        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fwd_all <= i_cfg_forward_all_types;
            end
            r_in_sentence <= n_in_sentence;
            if (o_pop) begin
                r_line_length  <= n_line_length;
                r_sep_count    <= n_sep_count;
                r_field_length <= n_field_length;
                r_xor          <= n_xor;
                r_star_seen    <= n_star_seen;
                r_hex_acc      <= n_hex_acc;
                r_last3        <= n_last3;
                r_type_flags   <= n_type_flags;
                r_limit        <= n_limit;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

`ifndef ASSERT_OFF
    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_sentence |-> (r_line_length < LINE_LIM)) else $error("line length overrun");
    a_sep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep_count <= SEP_LIM) else $error("separator count overrun");
    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status == STATUS_OK) |->
        (r_result.received_checksum == r_result.computed_checksum))
        else $error("ok status with checksum mismatch");
    a_fwd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.forward) |-> (r_result.status == STATUS_OK))
        else $error("forward set on bad sentence");
    a_no_emit_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit) else $error("result overwritten");
`endif

endmodule

FILE: hw/rtl/nmea_sentence_framer_checker.sv
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Depends on nsfc_pkg, nsfc_front, nsfc_queue, nsfc_back.
//
// Input channel: i_in_valid / o_in_stall carry one byte (i_rx_byte) and
// i_chunk_end per transfer. Output channel: o_out_valid / i_out_stall carry
// one result per carriage return that closes an open sentence: status,
// sentence type, field count, computed and received checksum, forward flag.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes
// forward_all_types; write it only while the block is idle.
// Throughput: one byte per cycle while no result is held by an output stall.
// A transferred byte is written into the byte queue and then popped by the back
// end; a closing carriage return loads the result register, which drives the
// output ports. The rate is set by the per-byte state update in the back end.
// When the receiver stalls a valid result, the result register holds, the back
// end stops, the two-entry byte queue fills and then o_in_stall rises.
// Reset (synchronous, active low) closes any open sentence, empties the
// queue and the result register, and clears forward_all_types.
module nmea_sentence_framer_checker #(
    parameter int unsigned MAX_LINE_BYTES  = 99,
    parameter int unsigned MAX_FIELDS      = 32,
    parameter int unsigned MAX_FIELD_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_sentence_type,
    output logic [5:0] o_field_count,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_received_checksum,
    output logic       o_forward,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_forward_all_types
);
    import nsfc_pkg::*;

    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    t_item   front_item;
    t_item   q_item;
    t_result result;

    assign o_cfg_ready = 1'b1;

    nsfc_front u_front (
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_chunk_end(i_chunk_end),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (front_item)
    );

    nsfc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    nsfc_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_FIELDS     (MAX_FIELDS),
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_valid              (q_valid),
        .i_item                 (q_item),
        .o_pop                  (pop),
        .i_cfg_we               (i_cfg_valid),
        .i_cfg_forward_all_types(i_cfg_forward_all_types),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_result               (result)
    );

    assign o_status            = result.status;
    assign o_sentence_type     = result.sentence_type;
    assign o_field_count       = result.field_count;
    assign o_computed_checksum = result.computed_checksum;
    assign o_received_checksum = result.received_checksum;
    assign o_forward           = result.forward;

endmodule

FILE: verif/nmea_sentence_framer_checker_tb.sv
// Self-checking testbench for nmea_sentence_framer_checker: directed lines, then random
// NMEA sentences, noise and broken lines, with random idle and stall bursts.
// Depends on nsfc_pkg and the RTL of the block; a scoreboard class predicts each result.
`timescale 1ns / 100ps

module nmea_sentence_framer_checker_tb;

    import nsfc_pkg::*;

    localparam int LINE_LIMIT  = 99;
    localparam int SEP_LIMIT   = 32;
    localparam int FIELD_LIMIT = 32;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef enum int {
        LINE_NORMAL,
        LINE_LONG,
        LINE_MANY_SEPS,
        LINE_LONG_FIELD,
        LINE_NOISE,
        LINE_BROKEN
    } t_line_kind;

    class t_nmea_scoreboard;
        logic        fwd_all;
        logic        open_flag;
        logic [6:0]  line_len;
        logic [5:0]  sep_cnt;
        logic [6:0]  field_len;
        logic [7:0]  run_xor;
        logic        star_flag;
        logic [8:0]  hex_acc;
        logic [23:0] tail3;
        logic [3:0]  name_hits;
        logic        over_limit;
        t_result     pending_q[$];
        int          n_bytes;
        int          n_checked;
        int          n_errors;
        int          n_status[3];

        function new();
            clear_line();
            open_flag = 1'b0;
            fwd_all   = 1'b0;
            n_bytes   = 0;
            n_checked = 0;
            n_errors  = 0;
            n_status  = '{0, 0, 0};
        endfunction

        function void clear_line();
            open_flag  = 1'b1;
            line_len   = '0;
            sep_cnt    = '0;
            field_len  = '0;
            run_xor    = '0;
            star_flag  = 1'b0;
            hex_acc    = '0;
            tail3      = '0;
            name_hits  = '0;
            over_limit = 1'b0;
        endfunction

        function logic [5:0] hex_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return 6'(c - CH_ZERO);
            if (c >= 8'h61 && c <= 8'h7A) return 6'(c - CH_LOW_A + 8'd10);
            if (c >= 8'h41 && c <= 8'h5A) return 6'(c - CH_UP_A + 8'd10);
            return 6'd0;
        endfunction

        function void absorb(logic [7:0] c);
            int   acc;
            logic is_sep;
            is_sep = (c == CH_COMMA) || (c == CH_STAR);
            if (sep_cnt == 0 && !is_sep && line_len < TYPE_WINDOW) begin
                tail3 = {tail3[15:0], c};
                if (line_len >= 2) begin
                    for (int k = 0; k < NUM_TYPES; k++)
                        if (tail3 == TYPE_NAMES[k]) name_hits[k] = 1'b1;
                end
            end
            if (star_flag) begin
                acc = int'(hex_acc) * 16 + int'(hex_value(c));
                hex_acc = (acc > int'(HEX_CLAMP)) ? HEX_CLAMP : 9'(acc);
            end else if (c == CH_STAR) begin
                star_flag = 1'b1;
            end else if (line_len >= 1) begin
                run_xor ^= c;
            end
            if (is_sep) begin
                field_len = '0;
                if (sep_cnt < SEP_LIMIT) sep_cnt++;
                if (sep_cnt >= SEP_LIMIT) over_limit = 1'b1;
            end else begin
                if (field_len < FIELD_LIMIT) field_len++;
                if (field_len >= FIELD_LIMIT) over_limit = 1'b1;
            end
            line_len++;
            if (line_len >= LINE_LIMIT) open_flag = 1'b0;
        endfunction

        // Called for every accepted input transfer.
        function void note_byte(logic [7:0] c, logic ce);
            t_result r;
            n_bytes++;
            if (c == CH_DOLLAR) clear_line();
            if (open_flag) begin
                if (c == CH_CR) begin
                    if (over_limit) r.status = STATUS_LIMIT;
                    else if (!star_flag || hex_acc != {1'b0, run_xor}) r.status = STATUS_BAD_SUM;
                    else r.status = STATUS_OK;
                    if (name_hits[0]) r.sentence_type = TYPE_RMC;
                    else if (name_hits[1]) r.sentence_type = TYPE_GSA;
                    else if (name_hits[2]) r.sentence_type = TYPE_GGA;
                    else if (name_hits[3]) r.sentence_type = TYPE_GSV;
                    else r.sentence_type = TYPE_OTHER;
                    r.field_count       = sep_cnt;
                    r.computed_checksum = run_xor;
                    r.received_checksum = (hex_acc > 9'd255) ? 8'hFF : hex_acc[7:0];
                    r.forward = (r.status == STATUS_OK) &&
                                (r.sentence_type == TYPE_RMC || r.sentence_type == TYPE_GSA ||
                                 r.sentence_type == TYPE_GGA || fwd_all);
                    pending_q.push_back(r);
                    open_flag = 1'b0;
                end else begin
                    absorb(c);
                end
            end
            if (ce) open_flag = 1'b0;
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $error("result transfer with no sentence pending");
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            match_field("status", want.status, got.status);
            match_field("sentence_type", want.sentence_type, got.sentence_type);
            match_field("field_count", want.field_count, got.field_count);
            match_field("computed_checksum", want.computed_checksum, got.computed_checksum);
            match_field("received_checksum", want.received_checksum, got.received_checksum);
            match_field("forward", want.forward, got.forward);
            n_checked++;
            n_status[want.status]++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       i_chunk_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_status;
    logic [2:0] o_sentence_type;
    logic [5:0] o_field_count;
    logic [7:0] o_computed_checksum;
    logic [7:0] o_received_checksum;
    logic       o_forward;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_forward_all_types;

    nmea_sentence_framer_checker #(
        .MAX_LINE_BYTES (LINE_LIMIT),
        .MAX_FIELDS     (SEP_LIMIT),
        .MAX_FIELD_BYTES(FIELD_LIMIT)
    ) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_rx_byte              (i_rx_byte),
        .i_chunk_end            (i_chunk_end),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_status               (o_status),
        .o_sentence_type        (o_sentence_type),
        .o_field_count          (o_field_count),
        .o_computed_checksum    (o_computed_checksum),
        .o_received_checksum    (o_received_checksum),
        .o_forward              (o_forward),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_forward_all_types(i_cfg_forward_all_types)
    );

    t_nmea_scoreboard sb;
    logic [7:0]       line_q[$];
    bit               idle_on;
    int               stall_left;

    initial begin
        i_clk                   = 1'b0;
        i_rst_n                 = 1'b0;
        i_in_valid              = 1'b0;
        i_rx_byte               = 8'h00;
        i_chunk_end             = 1'b0;
        i_out_stall             = 1'b0;
        i_cfg_valid             = 1'b0;
        i_cfg_forward_all_types = 1'b0;
        idle_on                 = 1'b0;
        stall_left              = 0;
        sb                      = new();
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d sentence results still pending", sb.pending_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: random stall bursts while idle_on is set.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_status, o_sentence_type, o_field_count,
                             o_computed_checksum, o_received_checksum, o_forward});
    end

    task automatic push_byte(logic [7:0] b, logic ce);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_chunk_end <= ce;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, ce);
    endtask

    task automatic send_line(int ce_at);
        for (int i = 0; i < line_q.size(); i++)
            push_byte(line_q[i], i == ce_at);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic fwd);
        @(negedge i_clk);
        i_cfg_valid             <= 1'b1;
        i_cfg_forward_all_types <= fwd;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.fwd_all = fwd;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return CH_UP_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] field_char();
        case ($urandom_range(0, 3))
            0, 1:    return CH_ZERO + 8'($urandom_range(0, 9));
            2:       return CH_DOT;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10) return CH_ZERO + 8'(n);
        return (lower ? CH_LOW_A : CH_UP_A) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_field(int len);
        line_q.push_back(CH_COMMA);
        repeat (len) line_q.push_back(field_char());
    endfunction

    function automatic void make_line(t_line_kind kind);
        int         first;
        int         target;
        logic [7:0] sum;
        logic [7:0] bad;
        line_q.delete();
        if (kind == LINE_NOISE)
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        first = line_q.size();
        line_q.push_back(CH_DOLLAR);
        case ($urandom_range(0, 3))
            0:       add_str("GP");
            1:       add_str("GN");
            2:       add_str("GL");
            default: repeat (2) line_q.push_back(rand_letter());
        endcase
        case ($urandom_range(0, 5))
            0:       add_str("RMC");
            1:       add_str("GSA");
            2:       add_str("GGA");
            3:       add_str("GSV");
            4:       repeat (3) line_q.push_back(8'($urandom_range(48, 90)));
            default: add_str(",GGA");
        endcase
        case (kind)
            LINE_MANY_SEPS: repeat ($urandom_range(28, 40)) add_field($urandom_range(0, 1));
            LINE_LONG_FIELD: begin
                line_q.push_back(CH_COMMA);
                repeat ($urandom_range(26, 36)) line_q.push_back(field_char());
            end
            LINE_LONG: begin
                // stored length straddles the line limit
                target = $urandom_range(LINE_LIMIT - 3, LINE_LIMIT + 2);
                while (line_q.size() + 8 <= target - 3) add_field(7);
                while (line_q.size() < target - 3) line_q.push_back(CH_ZERO);
            end
            default: repeat ($urandom_range(0, 8)) add_field($urandom_range(0, 6));
        endcase
        sum = 8'h00;
        for (int i = first + 1; i < line_q.size(); i++) sum ^= line_q[i];
        bad = sum ^ 8'($urandom_range(1, 255));
        case ((kind == LINE_LONG) ? 0 : $urandom_range(0, 9))
            6: begin
                line_q.push_back(CH_STAR);
                line_q.push_back(hex_char(sum[7:4], 1'b1));
                line_q.push_back(hex_char(sum[3:0], 1'b1));
            end
            7: begin
                line_q.push_back(CH_STAR);
                line_q.push_back(hex_char(bad[7:4], 1'b0));
                line_q.push_back(hex_char(bad[3:0], 1'b0));
            end
            8: ;
            9: begin
                line_q.push_back(CH_STAR);
                repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(32, 126)));
            end
            default: begin
                line_q.push_back(CH_STAR);
                line_q.push_back(hex_char(sum[7:4], 1'b0));
                line_q.push_back(hex_char(sum[3:0], 1'b0));
            end
        endcase
        line_q.push_back(CH_CR);
        if ($urandom_range(0, 1)) line_q.push_back(CH_LF);
    endfunction

    task automatic run_lines(int n_items);
        int         start;
        int         r;
        int         ce_at;
        t_line_kind kind;
        start = sb.n_bytes;
        while (sb.n_bytes - start < n_items) begin
            r = $urandom_range(0, 99);
            kind = (r < 66) ? LINE_NORMAL :
                   (r < 74) ? LINE_LONG :
                   (r < 80) ? LINE_MANY_SEPS :
                   (r < 86) ? LINE_LONG_FIELD :
                   (r < 93) ? LINE_NOISE : LINE_BROKEN;
            make_line(kind);
            if (kind == LINE_BROKEN) ce_at = $urandom_range(0, line_q.size() - 1);
            else ce_at = ($urandom_range(0, 7) == 0) ? line_q.size() - 1 : -1;
            send_line(ce_at);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_write(1'b0);
        idle_on = 1'b1;

        // noise and a carriage return outside any sentence
        line_q = '{8'h00, 8'hFF, CH_CR};
        send_line(1);
        // good GGA line
        line_q.delete();
        add_str("$GPGGA*56");
        line_q.push_back(CH_CR);
        send_line(-1);
        // restart on a second dollar, RMC without star, CR together with chunk end
        line_q.delete();
        add_str("$X$RMC");
        line_q.push_back(CH_CR);
        send_line(line_q.size() - 1);
        // star right after dollar, received value clamps
        line_q.delete();
        add_str("$*FFF");
        line_q.push_back(CH_CR);
        send_line(-1);
        settle();

        cfg_write(1'b1);
        run_lines(450);
        settle();
        cfg_write(1'b0);
        run_lines(450);
        settle();
        cfg_write(1'b1);
        idle_on = 1'b0;
        run_lines(700);
        settle();

        $display("Sent %0d bytes; checked %0d sentence results", sb.n_bytes, sb.n_checked);
        $display("  status ok %0d, bad checksum %0d, over limit %0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2]);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
